>>> design/acr_pkg.sv
// ============================================================================
// ARP cache resolver package
// Shared types, field widths and codes for the ARP cache resolver block.
// ============================================================================
package acr_pkg;

    localparam int IP_W       = 32;
    localparam int MAC_W      = 48;
    localparam int OPC_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [OPC_W-1:0] OPC_REQUEST  = 16'd1;
    localparam logic [OPC_W-1:0] OPC_RESPONSE = 16'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_IP     = 2'd0,
        CFG_OWN_MASK   = 2'd1,
        CFG_GATEWAY_IP = 2'd2,
        CFG_OWN_MAC    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_RESOLVED = 3'd0,
        ST_REQUEST  = 3'd1,
        ST_REPLY    = 3'd2,
        ST_LEARNED  = 3'd3,
        ST_NOT_OURS = 3'd4,
        ST_BAD_OP   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        KEY_LOOKUP  = 2'd0,
        KEY_GATEWAY = 2'd1,
        KEY_SENDER  = 2'd2
    } t_key_sel;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_DECIDE  = 3'd1,
        S_LOOKUP  = 3'd2,
        S_GATEWAY = 3'd3,
        S_LEARN   = 3'd4
    } t_acr_state;

    typedef struct packed {
        logic             operation;
        logic [OPC_W-1:0] arp_opcode;
        logic [IP_W-1:0]  sender_ip;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  target_ip;
        logic [IP_W-1:0]  lookup_ip;
    } t_arp_in;

    typedef struct packed {
        t_status          status;
        logic [MAC_W-1:0] mac_addr;
        logic [IP_W-1:0]  ip_addr;
    } t_arp_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     scan_start;
        t_key_sel key_sel;
        logic     learn;
        logic     emit;
        t_status  result;
    } t_acr_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_arp;
        logic opc_ok;
        logic opc_req;
        logic tgt_ours;
        logic on_subnet;
        logic scan_done;
        logic scan_hit;
    } t_acr_stat;

endpackage

>>> design/acr_datapath.sv
// ============================================================================
// ARP cache resolver datapath
// Configuration registers, item capture, cache memory with sequential scan,
// round-robin learning and the result register.
// ============================================================================
module acr_datapath import acr_pkg::*; #(
    parameter int CACHE_ENTRIES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_arp_in               i_in,
    input  t_acr_cmd              i_cmd,
    output t_acr_stat             o_stat,
    output logic                  o_done,
    output t_arp_out              o_out
);

    localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST = AW'(CACHE_ENTRIES - 1);
    localparam int EW = IP_W + MAC_W;

    logic [IP_W-1:0]     r_own_ip;
    logic [IP_W-1:0]     r_own_mask;
    logic [IP_W-1:0]     r_gateway_ip;
    t_arp_in             r_item;
    logic [IP_W-1:0]     r_key;
    logic [IP_W-1:0]     n_key;

    logic [EW-1:0]       mem [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] r_valid;
    logic [AW-1:0]       r_next_slot;
    logic [AW-1:0]       n_slot;

    logic                r_scan_active;
    logic                r_issuing;
    logic [AW-1:0]       r_rd_addr;
    logic                r_pend;
    logic                r_last;
    logic                r_rd_vld;
    logic [EW-1:0]       r_rd_data;
    logic                r_scan_done;
    logic                r_scan_hit;
    logic [MAC_W-1:0]    r_hit_mac;
    logic                rd_en;
    logic [IP_W-1:0]     entry_ip;
    logic [MAC_W-1:0]    entry_mac;
    logic                match;

    logic                r_done;
    t_arp_out            r_out;

    // Own MAC is only the sender of replies built elsewhere, so writes to it
    // are accepted and dropped here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip     <= '0;
            r_own_mask   <= '0;
            r_gateway_ip <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_OWN_IP:     r_own_ip     <= i_cfg_data[IP_W-1:0];
                CFG_OWN_MASK:   r_own_mask   <= i_cfg_data[IP_W-1:0];
                CFG_GATEWAY_IP: r_gateway_ip <= i_cfg_data[IP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.key_sel)
            KEY_LOOKUP:  n_key = r_item.lookup_ip;
            KEY_GATEWAY: n_key = r_gateway_ip;
            KEY_SENDER:  n_key = r_item.sender_ip;
            default:     n_key = r_item.lookup_ip;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
        end
        if (i_cmd.scan_start) begin
            r_key <= n_key;
        end
    end

    assign n_slot = (r_next_slot == LAST) ? '0 : r_next_slot + 1'b1;
    assign rd_en  = r_scan_active && r_issuing;

    // Cache memory: one write port for learning, one registered read port
    // for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.learn) begin
            mem[n_slot] <= {r_item.sender_ip, r_item.sender_mac};
        end
        if (rd_en) begin
            r_rd_data <= mem[r_rd_addr];
        end
    end

    // Entries never written read as zero IP and zero MAC.
    assign entry_ip  = r_rd_vld ? r_rd_data[EW-1:MAC_W] : '0;
    assign entry_mac = r_rd_vld ? r_rd_data[MAC_W-1:0]  : '0;
    assign match     = r_pend && (entry_ip == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_next_slot   <= '0;
            r_scan_active <= 1'b0;
            r_issuing     <= 1'b0;
            r_rd_addr     <= '0;
            r_pend        <= 1'b0;
            r_last        <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_scan_done   <= 1'b0;
            r_scan_hit    <= 1'b0;
        end else begin
            r_scan_done <= 1'b0;
            if (i_cmd.learn) begin
                r_next_slot     <= n_slot;
                r_valid[n_slot] <= 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_scan_active <= 1'b1;
                r_issuing     <= 1'b1;
                r_rd_addr     <= '0;
                r_pend        <= 1'b0;
                r_scan_hit    <= 1'b0;
            end else if (r_scan_active) begin
                r_pend <= rd_en;
                if (rd_en) begin
                    r_rd_vld <= r_valid[r_rd_addr];
                    r_last   <= (r_rd_addr == LAST);
                    if (r_rd_addr == LAST) begin
                        r_issuing <= 1'b0;
                    end else begin
                        r_rd_addr <= r_rd_addr + 1'b1;
                    end
                end
                // The lowest matching slot ends the scan.
                if (match) begin
                    r_scan_active <= 1'b0;
                    r_issuing     <= 1'b0;
                    r_pend        <= 1'b0;
                    r_scan_done   <= 1'b1;
                    r_scan_hit    <= 1'b1;
                end else if (r_pend && r_last) begin
                    r_scan_active <= 1'b0;
                    r_issuing     <= 1'b0;
                    r_pend        <= 1'b0;
                    r_scan_done   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (match) begin
            r_hit_mac <= entry_mac;
        end
    end

    always_comb begin
        o_stat.op_arp    = r_item.operation;
        o_stat.opc_ok    = (r_item.arp_opcode == OPC_REQUEST) ||
                           (r_item.arp_opcode == OPC_RESPONSE);
        o_stat.opc_req   = (r_item.arp_opcode == OPC_REQUEST);
        o_stat.tgt_ours  = (r_item.target_ip == r_own_ip);
        o_stat.on_subnet = ((r_item.lookup_ip & r_own_mask) == (r_own_ip & r_own_mask));
        o_stat.scan_done = r_scan_done;
        o_stat.scan_hit  = r_scan_hit;
    end

    // Result register. On a request the address to query is the key that
    // missed: the lookup IP or the gateway.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.status <= i_cmd.result;
            case (i_cmd.result)
                ST_RESOLVED: begin
                    r_out.mac_addr <= r_hit_mac;
                    r_out.ip_addr  <= '0;
                end
                ST_REQUEST: begin
                    r_out.mac_addr <= '0;
                    r_out.ip_addr  <= r_key;
                end
                ST_REPLY: begin
                    r_out.mac_addr <= r_item.sender_mac;
                    r_out.ip_addr  <= r_item.sender_ip;
                end
                default: begin
                    r_out.mac_addr <= '0;
                    r_out.ip_addr  <= '0;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

>>> design/acr_ctrl.sv
// ============================================================================
// ARP cache resolver controller
// Sequences capture, cache scans, learning and result issue.
// ============================================================================
module acr_ctrl import acr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_acr_stat i_stat,
    output t_acr_cmd  o_cmd,
    output logic      o_busy
);

    t_acr_state r_state;
    t_acr_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd.load       = 1'b0;
        o_cmd.scan_start = 1'b0;
        o_cmd.key_sel    = KEY_LOOKUP;
        o_cmd.learn      = 1'b0;
        o_cmd.emit       = 1'b0;
        o_cmd.result     = ST_RESOLVED;
        o_busy           = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_stat.op_arp) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.key_sel    = KEY_LOOKUP;
                    n_state          = S_LOOKUP;
                end else if (!i_stat.opc_ok) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.result = ST_BAD_OP;
                    n_state      = S_IDLE;
                end else if (!i_stat.tgt_ours) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.result = ST_NOT_OURS;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.key_sel    = KEY_SENDER;
                    n_state          = S_LEARN;
                end
            end
            S_LOOKUP: begin
                if (i_stat.scan_done) begin
                    if (i_stat.scan_hit) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.result = ST_RESOLVED;
                        n_state      = S_IDLE;
                    end else if (i_stat.on_subnet) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.result = ST_REQUEST;
                        n_state      = S_IDLE;
                    end else begin
                        // Off-subnet miss: resolve through the gateway.
                        o_cmd.scan_start = 1'b1;
                        o_cmd.key_sel    = KEY_GATEWAY;
                        n_state          = S_GATEWAY;
                    end
                end
            end
            S_GATEWAY: begin
                if (i_stat.scan_done) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.result = i_stat.scan_hit ? ST_RESOLVED : ST_REQUEST;
                    n_state      = S_IDLE;
                end
            end
            S_LEARN: begin
                if (i_stat.scan_done) begin
                    // A sender that is already cached keeps its old MAC.
                    o_cmd.learn  = !i_stat.scan_hit;
                    o_cmd.emit   = 1'b1;
                    o_cmd.result = i_stat.opc_req ? ST_REPLY : ST_LEARNED;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/arp_cache_resolver_top.sv
// ============================================================================
// ARP cache resolver
// Small IP-to-MAC cache that resolves destinations and learns from ARP beats.
// ============================================================================
//  Channel   Direction  Handshake                      Payload
//  item      in         i_start high while o_busy low  i_in  (t_arp_in)
//  result    out        o_done strobe, one cycle       o_out (t_arp_out)
//  config    in         i_cfg_we                       i_cfg_idx, i_cfg_data
//
//  A beat ends without a scan, after one cache scan, or after a second scan
//  for the gateway when an off-subnet miss occurs. The scan reads one cache
//  entry per cycle through the single registered memory read port.
//  The result strobe is high in the first cycle with o_busy low, and a new
//  beat may be taken in that cycle. Reset is synchronous and empties the cache
//  at once. The receiver cannot stall the result.
// ============================================================================
module arp_cache_resolver_top import acr_pkg::*; #(
    parameter int CACHE_ENTRIES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_arp_in               i_in,
    output logic                  o_busy,
    output logic                  o_done,
    output t_arp_out              o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_acr_cmd  cmd;
    t_acr_stat stat;

    acr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    acr_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_done     (o_done),
        .o_out      (o_out)
    );

endmodule

>>> tb/sv/arp_cache_resolver_top_tb.sv
// ============================================================================
// ARP cache resolver testbench
// Drives resolve and received-ARP beats through the command handshake, keeps
// a behavioral copy of the cache and registers, and checks every result beat
// field by field. A directed table comes first, then randomized phases under
// several register settings and sender idle rates.
// ============================================================================
`timescale 1ns / 100ps

module arp_cache_resolver_top_tb;
    import acr_pkg::*;

    localparam int CACHE_ENTRIES = 8;
    localparam int PHASES        = 6;
    localparam int PHASE_BEATS   = 267;
    localparam int POOL_SIZE     = 16;
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic [IP_W-1:0]  own_ip;
        logic [IP_W-1:0]  mask;
        logic [IP_W-1:0]  gw_ip;
        logic [MAC_W-1:0] mac;
    } t_settings;

    typedef struct packed {
        logic      is_cfg;
        t_settings cfg;
        t_arp_in   beat;
        logic      typed;
        t_arp_out  exp;
    } t_stim_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_start    = 1'b0;
    t_arp_in               i_in       = '0;
    logic                  o_busy;
    logic                  o_done;
    t_arp_out              o_out;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Hand-written expectation that travels with the beat it belongs to.
    logic     typed_valid = 1'b0;
    t_arp_out typed_out   = '0;

    // Behavioral copy of the block.
    logic [IP_W-1:0]  shadow_ip  [CACHE_ENTRIES];
    logic [MAC_W-1:0] shadow_mac [CACHE_ENTRIES];
    int               shadow_slot = 0;
    t_settings        shadow_cfg  = '0;

    t_arp_out    outcome_q[$];
    int          err_cnt = 0;
    int          beat_cnt = 0;
    int          status_seen[8];
    int unsigned cycle_cnt = 0;
    int          idle_pct = 0;
    int          setting_cnt = 0;
    t_settings   cur_cfg = '0;
    logic [IP_W-1:0] host_pool[POOL_SIZE];

    arp_cache_resolver_top #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_in       (i_in),
        .o_busy     (o_busy),
        .o_done     (o_done),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        for (int k = 0; k < CACHE_ENTRIES; k++) begin
            shadow_ip[k]  = '0;
            shadow_mac[k] = '0;
        end
        for (int k = 0; k < 8; k++) begin
            status_seen[k] = 0;
        end
    end

    function automatic logic cache_find(input logic [IP_W-1:0] ip,
                                        output logic [MAC_W-1:0] mac);
        mac = '0;
        for (int k = 0; k < CACHE_ENTRIES; k++) begin
            if (shadow_ip[k] == ip) begin
                mac = shadow_mac[k];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Works out the result of one beat and applies any learning to the copy.
    function automatic t_arp_out resolve_beat(input t_arp_in b);
        t_arp_out         r;
        logic [MAC_W-1:0] m;
        r.status   = ST_RESOLVED;
        r.mac_addr = '0;
        r.ip_addr  = '0;
        if (!b.operation) begin
            if (cache_find(b.lookup_ip, m)) begin
                r.mac_addr = m;
            end else if ((b.lookup_ip & shadow_cfg.mask) ==
                         (shadow_cfg.own_ip & shadow_cfg.mask)) begin
                r.status  = ST_REQUEST;
                r.ip_addr = b.lookup_ip;
            end else if (cache_find(shadow_cfg.gw_ip, m)) begin
                r.mac_addr = m;
            end else begin
                r.status  = ST_REQUEST;
                r.ip_addr = shadow_cfg.gw_ip;
            end
        end else if (b.arp_opcode != OPC_REQUEST && b.arp_opcode != OPC_RESPONSE) begin
            r.status = ST_BAD_OP;
        end else if (b.target_ip != shadow_cfg.own_ip) begin
            r.status = ST_NOT_OURS;
        end else begin
            // A known sender keeps its old MAC; a new one goes to the next slot.
            if (!cache_find(b.sender_ip, m)) begin
                shadow_slot = (shadow_slot == CACHE_ENTRIES - 1) ? 0 : shadow_slot + 1;
                shadow_ip[shadow_slot]  = b.sender_ip;
                shadow_mac[shadow_slot] = b.sender_mac;
            end
            if (b.arp_opcode == OPC_REQUEST) begin
                r.status   = ST_REPLY;
                r.mac_addr = b.sender_mac;
                r.ip_addr  = b.sender_ip;
            end else begin
                r.status = ST_LEARNED;
            end
        end
        return r;
    endfunction

    // Result checking, register tracking and prediction on accepted beats.
    always @(posedge i_clk) begin : monitor
        t_arp_out want;
        t_arp_out pred;
        if (i_rst_n) begin
            if (o_done) begin
                if (outcome_q.size() == 0) begin
                    $error("result beat with nothing pending: status %0d mac %h ip %h",
                           o_out.status, o_out.mac_addr, o_out.ip_addr);
                    err_cnt++;
                end else begin
                    want = outcome_q.pop_front();
                    if (o_out.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_out.status);
                        err_cnt++;
                    end
                    if (o_out.mac_addr !== want.mac_addr) begin
                        $error("mac_addr: expected %h, got %h", want.mac_addr, o_out.mac_addr);
                        err_cnt++;
                    end
                    if (o_out.ip_addr !== want.ip_addr) begin
                        $error("ip_addr: expected %h, got %h", want.ip_addr, o_out.ip_addr);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_OWN_IP:     shadow_cfg.own_ip = i_cfg_data[IP_W-1:0];
                    CFG_OWN_MASK:   shadow_cfg.mask   = i_cfg_data[IP_W-1:0];
                    CFG_GATEWAY_IP: shadow_cfg.gw_ip  = i_cfg_data[IP_W-1:0];
                    CFG_OWN_MAC:    shadow_cfg.mac    = i_cfg_data[MAC_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !o_busy) begin
                pred = resolve_beat(i_in);
                beat_cnt++;
                status_seen[pred.status]++;
                outcome_q.push_back(typed_valid ? typed_out : pred);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_arp_in lookup_beat(input logic [IP_W-1:0] ip);
        t_arp_in b;
        b           = '0;
        b.operation = 1'b0;
        b.lookup_ip = ip;
        return b;
    endfunction

    function automatic t_arp_in arp_beat(input logic [OPC_W-1:0] opc,
                                         input logic [IP_W-1:0] sip,
                                         input logic [MAC_W-1:0] smac,
                                         input logic [IP_W-1:0] tip);
        t_arp_in b;
        b            = '0;
        b.operation  = 1'b1;
        b.arp_opcode = opc;
        b.sender_ip  = sip;
        b.sender_mac = smac;
        b.target_ip  = tip;
        return b;
    endfunction

    function automatic t_stim_row beat_row(input t_arp_in b, input logic typed,
                                           input t_arp_out exp);
        t_stim_row r;
        r        = '0;
        r.beat   = b;
        r.typed  = typed;
        r.exp    = exp;
        return r;
    endfunction

    function automatic t_arp_out outcome(input t_status st, input logic [MAC_W-1:0] mac,
                                         input logic [IP_W-1:0] ip);
        t_arp_out r;
        r.status   = st;
        r.mac_addr = mac;
        r.ip_addr  = ip;
        return r;
    endfunction

    // Random beat biased toward addresses that the cache can actually hold.
    function automatic t_arp_in draw_beat();
        t_arp_in     b;
        logic [63:0] r;
        int          pick;
        r            = {$urandom(), $urandom()};
        b.operation  = 1'($urandom_range(0, 1));
        b.arp_opcode = 16'($urandom_range(0, 65535));
        b.sender_ip  = $urandom();
        b.sender_mac = r[MAC_W-1:0];
        b.target_ip  = $urandom();
        b.lookup_ip  = $urandom();
        if (b.operation) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                b.arp_opcode = $urandom_range(0, 1) ? OPC_RESPONSE : OPC_REQUEST;
            end else if (pick < 90) begin
                b.arp_opcode = '0;
            end else if (pick < 93) begin
                b.arp_opcode = '1;
            end else if (pick < 95) begin
                b.arp_opcode = 16'd3;
            end
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                b.target_ip = cur_cfg.own_ip;
            end else if (pick < 85) begin
                b.target_ip = host_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            if ($urandom_range(0, 99) < 80) begin
                b.sender_ip = host_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                b.lookup_ip = host_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else if (pick < 75) begin
                b.lookup_ip = (cur_cfg.own_ip & cur_cfg.mask) | (b.lookup_ip & ~cur_cfg.mask);
            end
        end
        return b;
    endfunction

    task automatic send_beat(input t_arp_in b, input logic has_typed, input t_arp_out typed);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            // Mostly short gaps; now and then one long enough to span a scan.
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_in        <= b;
        typed_valid <= has_typed;
        typed_out   <= typed;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_settings s);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_OWN_IP;
        i_cfg_data <= {16'h0, s.own_ip};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OWN_MASK;
        i_cfg_data <= {16'h0, s.mask};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_GATEWAY_IP;
        i_cfg_data <= {16'h0, s.gw_ip};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OWN_MAC;
        i_cfg_data <= s.mac;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_cfg    = s;
        setting_cnt++;
    endtask

    initial begin : stimulus
        t_stim_row   rows[$];
        t_settings   phase_cfg[PHASES];
        int          idle_plan[PHASES];
        t_stim_row   cfg_row;
        logic [63:0] r;
        int          len;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: every slot holds IP 0 and the whole space is on-subnet.
        rows.push_back(beat_row(lookup_beat(32'h0), 1'b1, outcome(ST_RESOLVED, '0, '0)));
        rows.push_back(beat_row(lookup_beat('1), 1'b1, outcome(ST_REQUEST, '0, '1)));
        rows.push_back(beat_row(arp_beat(16'h0, 32'h1, 48'h1, 32'h0), 1'b1,
                                outcome(ST_BAD_OP, '0, '0)));
        rows.push_back(beat_row(arp_beat(16'hFFFF, 32'h1, 48'h1, 32'h0), 1'b1,
                                outcome(ST_BAD_OP, '0, '0)));
        rows.push_back(beat_row(arp_beat(16'h3, 32'h1, 48'h1, 32'h0), 1'b1,
                                outcome(ST_BAD_OP, '0, '0)));
        rows.push_back(beat_row(arp_beat(OPC_REQUEST, '1, '1, 32'h0), 1'b1,
                                outcome(ST_REPLY, '1, '1)));
        rows.push_back(beat_row(lookup_beat('1), 1'b1, outcome(ST_RESOLVED, '1, '0)));
        // Sender already cached: the old MAC must survive.
        rows.push_back(beat_row(arp_beat(OPC_RESPONSE, 32'h0, 48'h1234_5678_9ABC, 32'h0),
                                1'b1, outcome(ST_LEARNED, '0, '0)));
        rows.push_back(beat_row(lookup_beat(32'h0), 1'b1, outcome(ST_RESOLVED, '0, '0)));

        cfg_row        = '0;
        cfg_row.is_cfg = 1'b1;
        cfg_row.cfg    = '{own_ip: 32'hC0A8_0105, mask: 32'hFFFF_FF00,
                           gw_ip: 32'hC0A8_0101, mac: 48'h0200_0000_0001};
        rows.push_back(cfg_row);

        rows.push_back(beat_row(arp_beat(OPC_REQUEST, 32'hC0A8_0109, 48'h5, 32'hC0A8_0106),
                                1'b1, outcome(ST_NOT_OURS, '0, '0)));
        rows.push_back(beat_row(lookup_beat(32'h0808_0808), 1'b1,
                                outcome(ST_REQUEST, '0, 32'hC0A8_0101)));
        rows.push_back(beat_row(lookup_beat(32'hC0A8_0177), 1'b1,
                                outcome(ST_REQUEST, '0, 32'hC0A8_0177)));
        rows.push_back(beat_row(arp_beat(OPC_RESPONSE, 32'hC0A8_0101, 48'hAABB_CCDD_EEFF,
                                         32'hC0A8_0105), 1'b1, outcome(ST_LEARNED, '0, '0)));
        rows.push_back(beat_row(lookup_beat(32'h0808_0808), 1'b1,
                                outcome(ST_RESOLVED, 48'hAABB_CCDD_EEFF, '0)));
        rows.push_back(beat_row(lookup_beat(32'hC0A8_0101), 1'b1,
                                outcome(ST_RESOLVED, 48'hAABB_CCDD_EEFF, '0)));
        // Fill the rest of the cache so the round robin wraps over slot 0.
        for (int k = 0; k < 6; k++) begin
            r = {$urandom(), $urandom()};
            rows.push_back(beat_row(arp_beat(OPC_REQUEST, 32'hC0A8_0110 + k, r[MAC_W-1:0],
                                             32'hC0A8_0105), 1'b0, '0));
        end
        rows.push_back(beat_row(lookup_beat(32'h0), 1'b0, '0));
        rows.push_back(beat_row(arp_beat(OPC_RESPONSE, 32'hC0A8_0120, 48'h0000_0000_0042,
                                         32'hC0A8_0105), 1'b0, '0));
        rows.push_back(beat_row(lookup_beat('1), 1'b0, '0));

        foreach (rows[k]) begin
            if (rows[k].is_cfg) begin
                drain_results();
                apply_settings(rows[k].cfg);
            end else begin
                send_beat(rows[k].beat, rows[k].typed, rows[k].exp);
            end
        end
        drain_results();

        phase_cfg[0] = '{own_ip: 32'h0A00_0005, mask: 32'hFFFF_FF00,
                         gw_ip: 32'h0A00_0001, mac: 48'h0A0B_0C0D_0E0F};
        phase_cfg[1] = '{own_ip: 32'h0A00_0005, mask: 32'h0000_0000,
                         gw_ip: 32'h0A00_0001, mac: 48'h0000_0000_0000};
        phase_cfg[2] = '{own_ip: 32'h8000_0001, mask: 32'hFFFF_FFFF,
                         gw_ip: 32'hFFFF_FFFF, mac: 48'h8000_0000_0001};
        phase_cfg[3] = '{own_ip: 32'hFFFF_FFFF, mask: 32'hFFFF_0000,
                         gw_ip: 32'hFFFF_0001, mac: 48'hFFFF_FFFF_FFFF};
        r   = {$urandom(), $urandom()};
        len = $urandom_range(0, 32);
        phase_cfg[4].own_ip = $urandom();
        phase_cfg[4].mask   = 32'(64'hFFFF_FFFF_0000_0000 >> len);
        phase_cfg[4].gw_ip  = $urandom();
        phase_cfg[4].mac    = r[MAC_W-1:0];
        // A gateway of 0 resolves only if an entry with IP 0 is cached.
        phase_cfg[5] = '{own_ip: 32'h0000_0000, mask: 32'hFFFF_FF00,
                         gw_ip: 32'h0000_0000, mac: 48'h5555_AAAA_5555};
        idle_plan = '{0, 59, 17, 0, 59, 17};

        for (int ph = 0; ph < PHASES; ph++) begin
            apply_settings(phase_cfg[ph]);
            idle_pct = idle_plan[ph];
            host_pool[0] = cur_cfg.gw_ip;
            host_pool[1] = cur_cfg.own_ip;
            host_pool[2] = '0;
            for (int k = 3; k < POOL_SIZE; k++) begin
                host_pool[k] = (k < 10) ?
                    ((cur_cfg.own_ip & cur_cfg.mask) | ($urandom() & ~cur_cfg.mask)) : $urandom();
            end
            for (int n = 0; n < PHASE_BEATS; n++) begin
                // Halfway through, hold off until the block has answered everything.
                if (n == PHASE_BEATS / 2) begin
                    drain_results();
                end
                send_beat(draw_beat(), 1'b0, '0);
            end
            drain_results();
        end

        repeat (30) @(posedge i_clk);
        $display("Summary: %0d beats under %0d register settings: %0d resolved, %0d query requests,",
                 beat_cnt, setting_cnt, status_seen[ST_RESOLVED], status_seen[ST_REQUEST]);
        $display("  %0d replies, %0d learned, %0d not addressed to us, %0d bad opcodes.",
                 status_seen[ST_REPLY], status_seen[ST_LEARNED], status_seen[ST_NOT_OURS],
                 status_seen[ST_BAD_OP]);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
